FILE: rtl/palette_background_compositor_core_macros.svh
// Assertion macros shared by the compositor RTL.
`ifndef PALETTE_BACKGROUND_COMPOSITOR_CORE_MACROS_SVH
`define PALETTE_BACKGROUND_COMPOSITOR_CORE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define PBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbc: assertion failed");

// Next-cycle implication, off while reset is held.
`define PBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbc: assertion failed");

`endif

FILE: rtl/pbc_pkg.sv
// Package: types, constants and helpers shared by the compositor modules.
`default_nettype none

package pbc_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;
    localparam int FG_COLORS_DEF     = 256;
    localparam int BG_BYTES_DEF      = 131072;

    // Working widths sized for the largest screen and image store supported
    localparam int CALC_XW = 11;
    localparam int CALC_YW = 11;
    localparam int CALC_AW = CALC_XW + CALC_YW;

    localparam int BG_PAL_DEPTH = 256;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [7:0] TRANSPARENT_IDX = 8'hFF;
    localparam logic [7:0] RED_MASK        = 8'hF8;
    localparam logic [7:0] GREEN_MASK      = 8'hFC;

    localparam logic [8:0] BG_WIDTH_RST  = 9'd320;
    localparam logic [7:0] BG_HEIGHT_RST = 8'd240;

    typedef enum logic [1:0] {
        REQ_COMPOSE = 2'd0,
        REQ_FG_WR   = 2'd1,
        REQ_BG_WR   = 2'd2,
        REQ_IMG_WR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        SRC_FG   = 2'd0,
        SRC_BG   = 2'd1,
        SRC_ZERO = 2'd2
    } t_src;

    typedef enum logic [1:0] {
        CFG_BG_ENABLE   = 2'd0,
        CFG_BG_WIDTH    = 2'd1,
        CFG_BG_HEIGHT   = 2'd2,
        CFG_BG_TOP_DOWN = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic       en;
        logic [8:0] width;
        logic [7:0] height;
        logic       top_down;
    } t_cfg;

    // One classified item as it crosses from the front to the back
    typedef struct packed {
        t_req               kind;
        t_src               src;
        logic               over;
        logic               wr_ok;
        logic [7:0]         slot;
        logic [15:0]        color;
        logic [CALC_AW-1:0] addr;
    } t_qent;

    function automatic logic [15:0] rgb_to_565(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        logic [7:0] rm;
        logic [7:0] gm;
        rm = r & RED_MASK;
        gm = g & GREEN_MASK;
        return {rm[7:3], gm[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pbc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/pbc_front.sv
// Front: accepts items, classifies them and computes the background address.
`default_nettype none

module pbc_front #(
    parameter int SCREEN_WIDTH  = pbc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pbc_pkg::SCREEN_HEIGHT_DEF,
    parameter int FG_COLORS     = pbc_pkg::FG_COLORS_DEF,
    parameter int BG_BYTES      = pbc_pkg::BG_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  pbc_pkg::t_cfg      i_cfg,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [8:0]    i_pos_x,
    input  wire logic [7:0]    i_pos_y,
    input  wire logic [7:0]    i_pix_index,
    input  wire logic [7:0]    i_red,
    input  wire logic [7:0]    i_green,
    input  wire logic [7:0]    i_blue,
    input  wire logic [16:0]   i_image_addr,
    output logic               o_push,
    output pbc_pkg::t_qent     o_ent,
    input  wire logic          i_full
);
    import pbc_pkg::*;

    localparam logic [CALC_XW-1:0] SW_C   = CALC_XW'(SCREEN_WIDTH);
    localparam logic [CALC_YW-1:0] SH_C   = CALC_YW'(SCREEN_HEIGHT);
    localparam logic [CALC_AW-1:0] BG_LIM = CALC_AW'(BG_BYTES);
    localparam logic [8:0]         FG_LIM = 9'(FG_COLORS);

    typedef struct packed {
        t_req               kind;
        logic [7:0]         idx;
        logic [15:0]        color;
        logic [CALC_AW-1:0] wr_addr;
        logic               wr_ok;
        logic               fg_ok;
        logic               transparent;
        logic               in_img;
        logic [CALC_YW-1:0] src_y;
        logic [CALC_XW-1:0] stride;
        logic [CALC_XW-1:0] xoff;
        logic [CALC_AW-1:0] prod;
    } t_fstage;

    t_fstage r_s1, n_s1, r_s2, n_s2;
    logic    r_s1_valid, r_s2_valid;
    logic    s1_ready, s2_ready;

    logic [CALC_XW-1:0] w_ext, w, left, x_e;
    logic [CALC_YW-1:0] h_ext, h, y_e;
    logic [CALC_AW-1:0] bg_addr;
    logic               bg_hit;

    assign s2_ready = !r_s2_valid || !i_full;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_stall  = !s1_ready;

    // Stage 1: clip the image to the screen and locate the pixel in it
    always_comb begin
        w_ext = CALC_XW'(i_cfg.width);
        h_ext = CALC_YW'(i_cfg.height);
        w     = (w_ext > SW_C) ? SW_C : w_ext;
        h     = (h_ext > SH_C) ? SH_C : h_ext;
        left  = SW_C - w;
        x_e   = CALC_XW'(i_pos_x);
        y_e   = CALC_YW'(i_pos_y);

        n_s1             = '0;
        n_s1.kind        = t_req'(i_req_type);
        n_s1.idx         = i_pix_index;
        n_s1.color       = rgb_to_565(i_red, i_green, i_blue);
        n_s1.wr_addr     = CALC_AW'(i_image_addr);
        n_s1.fg_ok       = {1'b0, i_pix_index} < FG_LIM;
        n_s1.transparent = i_pix_index == TRANSPARENT_IDX;
        n_s1.in_img      = i_cfg.en && (w != '0) && (h != '0) && (x_e >= left)
                           && (x_e < SW_C) && (y_e < h);
        n_s1.src_y       = i_cfg.top_down ? y_e : (h - CALC_YW'(1) - y_e);
        n_s1.stride      = (w + CALC_XW'(3)) & ~CALC_XW'(3);
        n_s1.xoff        = x_e - left;
        unique case (n_s1.kind)
            REQ_FG_WR:  n_s1.wr_ok = n_s1.fg_ok;
            REQ_BG_WR:  n_s1.wr_ok = 1'b1;
            REQ_IMG_WR: n_s1.wr_ok = n_s1.wr_addr < BG_LIM;
            default:    n_s1.wr_ok = 1'b0;
        endcase
    end

    // Stage 2: row offset
    always_comb begin
        n_s2      = r_s1;
        n_s2.prod = r_s1.src_y * r_s1.stride;
    end

    // Stage 3: final address and range check, written straight into the queue
    always_comb begin
        bg_addr = r_s2.prod + CALC_AW'(r_s2.xoff);
        bg_hit  = r_s2.in_img && (bg_addr < BG_LIM);

        o_ent       = '0;
        o_ent.kind  = r_s2.kind;
        o_ent.src   = SRC_FG;
        o_ent.wr_ok = r_s2.wr_ok;
        o_ent.color = r_s2.color;
        o_ent.slot  = r_s2.idx;
        o_ent.addr  = r_s2.wr_addr;
        if (r_s2.kind == REQ_COMPOSE) begin
            o_ent.slot = '0;
            if (!r_s2.transparent) begin
                o_ent.over = !r_s2.fg_ok;
                if (r_s2.fg_ok) begin
                    o_ent.slot = r_s2.idx;
                end
            end else if (bg_hit) begin
                o_ent.src  = SRC_BG;
                o_ent.addr = bg_addr;
            end else begin
                o_ent.src = SRC_ZERO;
            end
        end
    end

    assign o_push = r_s2_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1 <= n_s1;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pbc_queue.sv
// Queue: short FIFO of classified items between front and back.
`default_nettype none

`include "palette_background_compositor_core_macros.svh"

module pbc_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  pbc_pkg::t_qent i_wdata,
    input  wire logic      i_pop,
    output pbc_pkg::t_qent o_rdata,
    output logic           o_full,
    output logic           o_empty
);
    import pbc_pkg::*;

    t_qent             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_AW:0]     r_cnt, n_cnt;

    assign o_full  = r_cnt == (Q_AW + 1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    `PBC_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `PBC_ASSERT_IMP(a_q_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `PBC_ASSERT_NXT(a_q_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_empty)

endmodule

`default_nettype wire

FILE: rtl/pbc_back.sv
// Back: image and palette lookups, palette and image writes, result register.
`default_nettype none

`include "palette_background_compositor_core_macros.svh"

module pbc_back #(
    parameter int FG_COLORS = pbc_pkg::FG_COLORS_DEF,
    parameter int BG_BYTES  = pbc_pkg::BG_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  pbc_pkg::t_qent   i_head,
    input  wire logic        i_head_valid,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_pixel_word,
    output logic [1:0]       o_color_source,
    output logic             o_index_over
);
    import pbc_pkg::*;

    localparam int IMG_AW = $clog2(BG_BYTES);
    localparam int FG_AW  = $clog2(FG_COLORS);

    logic        adv;
    t_qent       r_b1, r_b2;
    logic        r_b1_valid, r_b2_valid;
    logic        img_we, fg_we, bg_we;
    logic [7:0]  img_rdata;
    logic [15:0] fg_rdata, bg_rdata;
    logic [FG_COLORS-1:0]    r_fg_vld;
    logic [BG_PAL_DEPTH-1:0] r_bg_vld;
    logic        r_fg_rv, r_bg_rv;
    logic [15:0] color;
    logic        r_out_valid;
    logic [15:0] r_pixel_word;
    logic [1:0]  r_color_source;
    logic        r_index_over;

    // The whole back pipeline moves only when the result register can take
    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && i_head_valid;

    assign img_we = o_pop && (i_head.kind == REQ_IMG_WR) && i_head.wr_ok;
    assign fg_we  = adv && r_b1_valid && (r_b1.kind == REQ_FG_WR) && r_b1.wr_ok;
    assign bg_we  = adv && r_b1_valid && (r_b1.kind == REQ_BG_WR);

    pbc_ram #(.WIDTH(8), .DEPTH(BG_BYTES)) u_img_ram (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (i_head.addr[IMG_AW-1:0]),
        .i_wdata (i_head.slot),
        .i_re    (adv),
        .i_raddr (i_head.addr[IMG_AW-1:0]),
        .o_rdata (img_rdata)
    );

    pbc_ram #(.WIDTH(16), .DEPTH(FG_COLORS)) u_fg_ram (
        .i_clk   (i_clk),
        .i_we    (fg_we),
        .i_waddr (r_b1.slot[FG_AW-1:0]),
        .i_wdata (r_b1.color),
        .i_re    (adv),
        .i_raddr (r_b1.slot[FG_AW-1:0]),
        .o_rdata (fg_rdata)
    );

    pbc_ram #(.WIDTH(16), .DEPTH(BG_PAL_DEPTH)) u_bg_ram (
        .i_clk   (i_clk),
        .i_we    (bg_we),
        .i_waddr (r_b1.slot),
        .i_wdata (r_b1.color),
        .i_re    (adv),
        .i_raddr (img_rdata),
        .o_rdata (bg_rdata)
    );

    // Palette entries never written since reset read as zero
    always_comb begin
        case (r_b2.src)
            SRC_BG:   color = r_bg_rv ? bg_rdata : '0;
            SRC_ZERO: color = r_fg_rv ? fg_rdata : '0;
            default:  color = (r_b2.over || !r_fg_rv) ? 16'h0000 : fg_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fg_vld    <= '0;
            r_bg_vld    <= '0;
        end else if (adv) begin
            r_b1_valid  <= i_head_valid;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid && (r_b2.kind == REQ_COMPOSE);
            if (fg_we) begin
                r_fg_vld[r_b1.slot[FG_AW-1:0]] <= 1'b1;
            end
            if (bg_we) begin
                r_bg_vld[r_b1.slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1           <= i_head;
            r_b2           <= r_b1;
            r_fg_rv        <= r_fg_vld[r_b1.slot[FG_AW-1:0]];
            r_bg_rv        <= r_bg_vld[img_rdata];
            r_pixel_word   <= {color[7:0], color[15:8]};
            r_color_source <= r_b2.src;
            r_index_over   <= r_b2.over;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_word   = r_pixel_word;
    assign o_color_source = r_color_source;
    assign o_index_over   = r_index_over;

    `PBC_ASSERT_NXT(a_compose_gives_result, i_clk, i_rst_n, adv && r_b2_valid && (r_b2.kind == REQ_COMPOSE), r_out_valid)
    `PBC_ASSERT_NXT(a_write_gives_none, i_clk, i_rst_n, adv && (!r_b2_valid || (r_b2.kind != REQ_COMPOSE)), !r_out_valid)
    `PBC_ASSERT_IMP(a_over_is_black, i_clk, i_rst_n, r_out_valid && r_index_over, (r_pixel_word == 16'h0000) && (r_color_source == SRC_FG))

endmodule

`default_nettype wire

FILE: rtl/palette_background_compositor_core.sv
// Top level: configuration registers, front, queue and back of the compositor.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one item per cycle while o_stall
//   is low: a compose request (screen coordinate and pixel index), a
//   foreground or background palette write (RGB888, stored as RGB565),
//   or a background image byte. Only compose requests give a result on the
//   output channel (o_valid / i_stall): a byte-swapped RGB565 word, its
//   color source and the index-over flag. Results leave in request order.
//   Throughput is one item per cycle while neither side stalls. From input
//   acceptance to o_valid an item passes two front stages (the second holds
//   the row multiplier), one queue slot, the registered image RAM read and
//   the registered palette read, then the result register.
//   When the receiver stalls, the result register holds, the back pipeline
//   freezes and the four-entry queue absorbs further front output; o_stall
//   rises once the queue and both front stages are full.
//   Reset clears all pipeline valids and both palettes (through per-entry
//   valid bits, at once) and loads the configuration defaults. Write the
//   configuration port only while no item is in flight.
`default_nettype none

module palette_background_compositor_core #(
    parameter int SCREEN_WIDTH  = pbc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pbc_pkg::SCREEN_HEIGHT_DEF,
    parameter int FG_COLORS     = pbc_pkg::FG_COLORS_DEF,
    parameter int BG_BYTES      = pbc_pkg::BG_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [8:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [7:0]  i_pix_index,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [16:0] i_image_addr,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_pixel_word,
    output logic [1:0]       o_color_source,
    output logic             o_index_over
);
    import pbc_pkg::*;

    t_cfg  r_cfg;
    t_qent front_ent, head_ent;
    logic  push, pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.en       <= 1'b0;
            r_cfg.width    <= BG_WIDTH_RST;
            r_cfg.height   <= BG_HEIGHT_RST;
            r_cfg.top_down <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_BG_ENABLE:   r_cfg.en       <= i_cfg_data[0];
                CFG_BG_WIDTH:    r_cfg.width    <= i_cfg_data;
                CFG_BG_HEIGHT:   r_cfg.height   <= i_cfg_data[7:0];
                CFG_BG_TOP_DOWN: r_cfg.top_down <= i_cfg_data[0];
            endcase
        end
    end

    pbc_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FG_COLORS     (FG_COLORS),
        .BG_BYTES      (BG_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pix_index  (i_pix_index),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_image_addr (i_image_addr),
        .o_push       (push),
        .o_ent        (front_ent),
        .i_full       (q_full)
    );

    pbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_ent),
        .i_pop   (pop),
        .o_rdata (head_ent),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pbc_back #(
        .FG_COLORS (FG_COLORS),
        .BG_BYTES  (BG_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_ent),
        .i_head_valid   (!q_empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_word   (o_pixel_word),
        .o_color_source (o_color_source),
        .o_index_over   (o_index_over)
    );

endmodule

`default_nettype wire
